/* src/t8cpu_pkg.sv */
// ----------------------------------------------------------------------------
// t8cpu_pkg
// Shared types and constants for the tiny 8-bit CPU execute block.
// ----------------------------------------------------------------------------
package t8cpu_pkg;

  localparam int unsigned DW       = 8;   // data path width
  localparam int unsigned NREGS    = 8;   // register file depth
  localparam int unsigned RIW      = 3;   // register index width
  localparam int unsigned IW_W     = 20;  // instruction word width
  localparam int unsigned QDEPTH   = 2;   // decode queue depth
  localparam int unsigned QAW      = 1;   // queue pointer width
  localparam int unsigned IN_TDW   = 32;
  localparam int unsigned OUT_TDW  = 48;

  typedef enum logic [2:0] {
    OP_ADD   = 3'd0,
    OP_ADDI  = 3'd1,
    OP_MUL   = 3'd2,
    OP_INV   = 3'd3,
    OP_BR    = 3'd4,
    OP_LOAD  = 3'd5,
    OP_STORE = 3'd6,
    OP_HALT  = 3'd7
  } opc_t;

  // branch conditions, carried in the d field
  localparam logic [RIW-1:0] BR_EQ = 3'd0;
  localparam logic [RIW-1:0] BR_NE = 3'd1;
  localparam logic [RIW-1:0] BR_LT = 3'd2;

  // input tuser: item kind
  localparam logic KIND_INSTR = 1'b0;
  localparam logic KIND_LDRET = 1'b1;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_HALTED = 2'd1,
    ST_BUSY   = 2'd2,
    ST_NOLOAD = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    REQ_NONE  = 2'd0,
    REQ_READ  = 2'd1,
    REQ_WRITE = 2'd2
  } req_t;

  // decoded item handed from front to back
  typedef struct packed {
    logic           is_ret;
    opc_t           opc;
    logic [RIW-1:0] d;
    logic [RIW-1:0] s;
    logic [RIW-1:0] t;
    logic [DW-1:0]  dat;   // imm for instructions, returned byte for load returns
  } dec_t;

  // result item, last field in the low bits
  typedef struct packed {
    status_t        status;
    logic           halted_flag;
    logic [DW-1:0]  written_value;
    logic [RIW-1:0] written_index;
    logic           reg_written;
    logic [DW-1:0]  mem_write_data;
    logic [DW-1:0]  mem_address;
    req_t           mem_request;
    logic [DW-1:0]  fetch_pc;
  } res_t;

  localparam int unsigned RES_W = $bits(res_t);

endpackage

/* src/tiny_eight_bit_cpu_execute.sv */
// ----------------------------------------------------------------------------
// tiny_eight_bit_cpu_execute
// Execute stage of a tiny 8-bit CPU with eight registers and an 8-bit PC.
// ----------------------------------------------------------------------------
// Input stream: in_tuser selects the kind of item (0 instruction word,
// 1 byte returned for an earlier load); in_tdata carries both payloads.
// Every accepted item yields exactly one result on the out_ stream,
// in order, carrying the next fetch PC, any memory request, any register
// write, the halted flag and a status code.
// Path: an accepted item is written into the queue, popped from it into
// the execute stage with its register file read, and executed into the
// output register. Throughput: one item per cycle while out_tready is high;
// the register file read and combinational ALU/branch unit set that figure.
// A two-entry queue parts the input from the execute stage; when the
// receiver holds out_tready low the output register, the execute stage
// and the queue fill, and in_tready drops once the queue is full.
// Synchronous reset clears PC, halted and load-pending state, empties the
// queue and marks all registers as zero; the block is ready right after.
// ----------------------------------------------------------------------------
module tiny_eight_bit_cpu_execute (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [t8cpu_pkg::IN_TDW-1:0]  in_tdata,   // instr_word[19:0], load_data[27:20]
  input  logic                          in_tuser,   // item kind: 0 instruction word, 1 load return
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [t8cpu_pkg::OUT_TDW-1:0] out_tdata   // fetch_pc[7:0], mem_request[9:8],
                                                    // mem_address[17:10],
                                                    // mem_write_data[25:18],
                                                    // reg_written[26],
                                                    // written_index[29:27],
                                                    // written_value[37:30],
                                                    // halted_flag[38], status[40:39]
);

  logic            q_full, push, pop, q_vld;
  t8cpu_pkg::dec_t push_item, q_item;

  t8cpu_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  t8cpu_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .q_vld     (q_vld),
    .q_item    (q_item)
  );

  t8cpu_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_vld      (q_vld),
    .q_item     (q_item),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  t8cpu_pkg::res_t out_res;
  assign out_res = out_tdata[t8cpu_pkg::RES_W-1:0];

  // an ignored item neither writes a register nor touches memory
  a_ignored_no_effect: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_res.status != t8cpu_pkg::ST_OK |->
      !out_res.reg_written && out_res.mem_request == t8cpu_pkg::REQ_NONE)
    else $error("ignored item shows side effects");

  a_halted_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_res.status == t8cpu_pkg::ST_HALTED |-> out_res.halted_flag)
    else $error("halted status without halted flag");

  a_store_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_res.mem_request == t8cpu_pkg::REQ_WRITE |-> !out_res.reg_written)
    else $error("store also writes a register");

  // a full queue must hold off the input
  a_full_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !in_tready && !push)
    else $error("push into full queue");

endmodule

/* src/t8cpu_ram.sv */
// ----------------------------------------------------------------------------
// t8cpu_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module t8cpu_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr0,
  input  logic [$clog2(DEPTH)-1:0] raddr1,
  output logic [WIDTH-1:0]         rdata0,
  output logic [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata0 <= mem_r[raddr0];
      rdata1 <= mem_r[raddr1];
    end
  end

endmodule

/* src/t8cpu_front.sv */
// ----------------------------------------------------------------------------
// t8cpu_front
// Input side: takes stream items and splits them into decoded fields.
// ----------------------------------------------------------------------------
module t8cpu_front (
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [t8cpu_pkg::IN_TDW-1:0]  in_tdata,
  input  logic                          in_tuser,
  input  logic                          q_full,
  output logic                          push,
  output t8cpu_pkg::dec_t               push_item
);

  logic [t8cpu_pkg::IW_W-1:0] word;
  logic [t8cpu_pkg::DW-1:0]   ld_byte;

  assign word    = in_tdata[t8cpu_pkg::IW_W-1:0];
  assign ld_byte = in_tdata[t8cpu_pkg::IW_W +: t8cpu_pkg::DW];

  assign in_tready = !q_full;
  assign push      = in_tvalid && !q_full;

  always_comb begin
    push_item.is_ret = (in_tuser == t8cpu_pkg::KIND_LDRET);
    push_item.opc    = t8cpu_pkg::opc_t'(word[19:17]);
    push_item.d      = word[16:14];
    push_item.s      = word[13:11];
    push_item.t      = word[10:8];
    push_item.dat    = push_item.is_ret ? ld_byte : word[7:0];
  end

endmodule

/* src/t8cpu_queue.sv */
// ----------------------------------------------------------------------------
// t8cpu_queue
// Short FIFO of decoded items between the front and back parts.
// ----------------------------------------------------------------------------
module t8cpu_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  t8cpu_pkg::dec_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            q_vld,
  output t8cpu_pkg::dec_t q_item
);

  t8cpu_pkg::dec_t             ent_r [t8cpu_pkg::QDEPTH];
  logic [t8cpu_pkg::QAW-1:0]   wp_r, wp_nxt;
  logic [t8cpu_pkg::QAW-1:0]   rp_r, rp_nxt;
  logic [t8cpu_pkg::QAW:0]     cnt_r, cnt_nxt;

  assign full   = (cnt_r == (t8cpu_pkg::QAW+1)'(t8cpu_pkg::QDEPTH));
  assign q_vld  = (cnt_r != '0);
  assign q_item = ent_r[rp_r];

  always_comb begin
    wp_nxt  = push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = pop  ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= push_item;
    end
  end

endmodule

/* src/t8cpu_back.sv */
// ----------------------------------------------------------------------------
// t8cpu_back
// Execute side: register file read into the execute stage, then output register.
// ----------------------------------------------------------------------------
module t8cpu_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_vld,
  input  t8cpu_pkg::dec_t               q_item,
  output logic                          pop,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [t8cpu_pkg::OUT_TDW-1:0] out_tdata
);

  localparam int unsigned DW  = t8cpu_pkg::DW;
  localparam int unsigned RIW = t8cpu_pkg::RIW;

  // execute stage
  logic            b_vld_r;
  t8cpu_pkg::dec_t b_item_r;
  logic            s_ok_r, t_ok_r;
  logic            fire, b_load;

  // architectural state
  logic [t8cpu_pkg::NREGS-1:0] rf_vld_r;
  logic [DW-1:0]               pc_r, pc_nxt;
  logic                        halted_r, halted_nxt;
  logic                        pend_r, pend_nxt;
  logic [RIW-1:0]              dest_r, dest_nxt;

  // last register write, covers the one the RAM read missed
  logic           fwd_vld_r;
  logic [RIW-1:0] fwd_idx_r;
  logic [DW-1:0]  fwd_val_r;

  logic [DW-1:0]  rd0, rd1, rs, rt, prod;
  logic           take;
  t8cpu_pkg::res_t res;

  logic                 out_vld_r;
  t8cpu_pkg::res_t      out_res_r;

  assign fire   = b_vld_r && (!out_vld_r || out_tready);
  assign b_load = !b_vld_r || fire;
  assign pop    = q_vld && b_load;

  t8cpu_ram #(
    .WIDTH (DW),
    .DEPTH (t8cpu_pkg::NREGS)
  ) u_rf (
    .clk    (clk),
    .we     (fire && res.reg_written),
    .waddr  (res.written_index),
    .wdata  (res.written_value),
    .re     (pop),
    .raddr0 (q_item.s),
    .raddr1 (q_item.t),
    .rdata0 (rd0),
    .rdata1 (rd1)
  );

  always_comb begin
    if (fwd_vld_r && fwd_idx_r == b_item_r.s) begin
      rs = fwd_val_r;
    end else begin
      rs = s_ok_r ? rd0 : '0;
    end
    if (fwd_vld_r && fwd_idx_r == b_item_r.t) begin
      rt = fwd_val_r;
    end else begin
      rt = t_ok_r ? rd1 : '0;
    end
  end

  assign prod = {4'b0, rs[7:4]} * {4'b0, rs[3:0]};

  always_comb begin
    unique case (b_item_r.d)
      t8cpu_pkg::BR_EQ: take = (rs == rt);
      t8cpu_pkg::BR_NE: take = (rs != rt);
      t8cpu_pkg::BR_LT: take = ($signed(rs) < $signed(rt));
      default:          take = 1'b0;
    endcase
  end

  always_comb begin
    pc_nxt     = pc_r;
    halted_nxt = halted_r;
    pend_nxt   = pend_r;
    dest_nxt   = dest_r;
    res        = '0;
    res.status = t8cpu_pkg::ST_OK;
    priority if (halted_r) begin
      res.status = t8cpu_pkg::ST_HALTED;
    end else if (b_item_r.is_ret) begin
      if (pend_r) begin
        res.reg_written   = 1'b1;
        res.written_index = dest_r;
        res.written_value = b_item_r.dat;
        pend_nxt          = 1'b0;
      end else begin
        res.status = t8cpu_pkg::ST_NOLOAD;
      end
    end else if (pend_r) begin
      res.status = t8cpu_pkg::ST_BUSY;
    end else begin
      pc_nxt = pc_r + 1'b1;
      unique case (b_item_r.opc)
        t8cpu_pkg::OP_ADD: begin
          res.reg_written   = 1'b1;
          res.written_value = rs + rt;
        end
        t8cpu_pkg::OP_ADDI: begin
          res.reg_written   = 1'b1;
          res.written_value = rs + b_item_r.dat;
        end
        t8cpu_pkg::OP_MUL: begin
          res.reg_written   = 1'b1;
          res.written_value = prod;
        end
        t8cpu_pkg::OP_INV: begin
          res.reg_written   = 1'b1;
          res.written_value = ~rs;
        end
        t8cpu_pkg::OP_BR: begin
          if (take) begin
            pc_nxt = b_item_r.dat;
          end
        end
        t8cpu_pkg::OP_LOAD: begin
          res.mem_request = t8cpu_pkg::REQ_READ;
          res.mem_address = rt;
          pend_nxt        = 1'b1;
          dest_nxt        = b_item_r.d;
        end
        t8cpu_pkg::OP_STORE: begin
          res.mem_request    = t8cpu_pkg::REQ_WRITE;
          res.mem_address    = rt;
          res.mem_write_data = rs;
        end
        t8cpu_pkg::OP_HALT: begin
          halted_nxt = 1'b1;
        end
      endcase
      if (res.reg_written) begin
        res.written_index = b_item_r.d;
      end
    end
    res.fetch_pc    = pc_nxt;
    res.halted_flag = halted_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r   <= 1'b0;
      rf_vld_r  <= '0;
      pc_r      <= '0;
      halted_r  <= 1'b0;
      pend_r    <= 1'b0;
      dest_r    <= '0;
      fwd_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (b_load) begin
        b_vld_r <= q_vld;
      end
      if (fire) begin
        pc_r     <= pc_nxt;
        halted_r <= halted_nxt;
        pend_r   <= pend_nxt;
        dest_r   <= dest_nxt;
        if (res.reg_written) begin
          rf_vld_r[res.written_index] <= 1'b1;
          fwd_vld_r                   <= 1'b1;
        end
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      b_item_r <= q_item;
      s_ok_r   <= rf_vld_r[q_item.s];
      t_ok_r   <= rf_vld_r[q_item.t];
    end
    if (fire && res.reg_written) begin
      fwd_idx_r <= res.written_index;
      fwd_val_r <= res.written_value;
    end
    if (fire) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {(t8cpu_pkg::OUT_TDW - t8cpu_pkg::RES_W)'(0), out_res_r};

endmodule

/* sim/tiny_eight_bit_cpu_execute_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tiny_eight_bit_cpu_execute_tb
// Self-checking bench for the CPU execute stage. An in-bench predictor keeps
// its own register file, PC, halt and load state, and works out the result
// of every accepted instruction or load-return transaction. Each output
// transaction is checked field by field against the oldest predicted result.
// Both stream sides idle at random. A long output hold-off and a full drain
// pause are included. Halt is sticky, so it is exercised last.
// ----------------------------------------------------------------------------
module tiny_eight_bit_cpu_execute_tb;

  localparam int unsigned DW      = t8cpu_pkg::DW;
  localparam int unsigned NREGS   = t8cpu_pkg::NREGS;
  localparam int unsigned RIW     = t8cpu_pkg::RIW;
  localparam int unsigned IW_W    = t8cpu_pkg::IW_W;
  localparam int unsigned IN_TDW  = t8cpu_pkg::IN_TDW;
  localparam int unsigned OUT_TDW = t8cpu_pkg::OUT_TDW;
  localparam int unsigned RES_W   = t8cpu_pkg::RES_W;

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [IN_TDW-1:0]   in_tdata;
  logic                in_tuser;
  logic                out_tvalid;
  logic                out_tready;
  logic [OUT_TDW-1:0]  out_tdata;

  tiny_eight_bit_cpu_execute DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // predictor state
  logic [DW-1:0]  gpr [NREGS];
  logic [DW-1:0]  pc_q;
  logic           halt_q;
  logic           ld_busy;
  logic [RIW-1:0] ld_dst;

  t8cpu_pkg::res_t retired_q [$];

  bit tx_idle_en;
  bit rx_idle_en;
  int hold_len = 0;
  int n_err = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_status [4] = '{0, 0, 0, 0};

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("** tiny_eight_bit_cpu_execute: FAILED **");
    $finish;
  end

  // mostly back-to-back, some short gaps, a few long ones
  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 90) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 8);
    return $urandom_range(15, 40);
  endfunction

  function automatic logic [IW_W-1:0] iw(t8cpu_pkg::opc_t opc, logic [RIW-1:0] d,
                                         logic [RIW-1:0] s, logic [RIW-1:0] t,
                                         logic [DW-1:0] imm);
    return {opc, d, s, t, imm};
  endfunction

  // executes one transaction on the predictor state, returns the result
  function automatic t8cpu_pkg::res_t retire_item(logic kind, logic [IW_W-1:0] word,
                                                  logic [DW-1:0] ldata);
    t8cpu_pkg::res_t r;
    t8cpu_pkg::opc_t opc;
    logic [RIW-1:0]  d, s, t;
    logic [DW-1:0]   imm, rs, rt;
    logic            take;
    r    = '0;
    opc  = t8cpu_pkg::opc_t'(word[19:17]);
    d    = word[16:14];
    s    = word[13:11];
    t    = word[10:8];
    imm  = word[7:0];
    rs   = gpr[s];
    rt   = gpr[t];
    take = 1'b0;
    if (halt_q) begin
      r.status = t8cpu_pkg::ST_HALTED;
    end else if (kind == t8cpu_pkg::KIND_LDRET) begin
      if (ld_busy) begin
        gpr[ld_dst]     = ldata;
        r.reg_written   = 1'b1;
        r.written_index = ld_dst;
        r.written_value = ldata;
        ld_busy         = 1'b0;
      end else begin
        r.status = t8cpu_pkg::ST_NOLOAD;
      end
    end else if (ld_busy) begin
      r.status = t8cpu_pkg::ST_BUSY;
    end else begin
      pc_q = pc_q + 1'b1;
      case (opc)
        t8cpu_pkg::OP_ADD: begin
          r.reg_written   = 1'b1;
          r.written_value = rs + rt;
        end
        t8cpu_pkg::OP_ADDI: begin
          r.reg_written   = 1'b1;
          r.written_value = rs + imm;
        end
        t8cpu_pkg::OP_MUL: begin
          r.reg_written   = 1'b1;
          r.written_value = {4'b0, rs[7:4]} * {4'b0, rs[3:0]};
        end
        t8cpu_pkg::OP_INV: begin
          r.reg_written   = 1'b1;
          r.written_value = ~rs;
        end
        t8cpu_pkg::OP_BR: begin
          case (d)
            t8cpu_pkg::BR_EQ: take = (rs == rt);
            t8cpu_pkg::BR_NE: take = (rs != rt);
            t8cpu_pkg::BR_LT: take = ($signed(rs) < $signed(rt));
            default:          take = 1'b0;
          endcase
          if (take) pc_q = imm;
        end
        t8cpu_pkg::OP_LOAD: begin
          r.mem_request = t8cpu_pkg::REQ_READ;
          r.mem_address = rt;
          ld_busy       = 1'b1;
          ld_dst        = d;
        end
        t8cpu_pkg::OP_STORE: begin
          r.mem_request    = t8cpu_pkg::REQ_WRITE;
          r.mem_address    = rt;
          r.mem_write_data = rs;
        end
        default: halt_q = 1'b1;
      endcase
      if (r.reg_written) begin
        r.written_index = d;
        gpr[d]          = r.written_value;
      end
    end
    r.fetch_pc    = pc_q;
    r.halted_flag = halt_q;
    return r;
  endfunction

  task automatic send_item(logic kind, logic [IW_W-1:0] word, logic [DW-1:0] ldata);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {{(IN_TDW-IW_W-DW){1'b0}}, ldata, word};
    do @(posedge clk); while (!in_tready);
    retired_q.push_back(retire_item(kind, word, ldata));
    n_sent++;
    gap = tx_idle_en ? pick_gap() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // well-formed most of the time: a pending load is usually answered next
  task automatic send_random(bit allow_halt);
    logic              kind;
    logic [IW_W-1:0]   word;
    logic [DW-1:0]     ldata;
    int                p;
    word  = IW_W'($urandom);
    ldata = DW'($urandom);
    p     = $urandom_range(0, 99);
    word[19:17] = allow_halt ? 3'($urandom_range(0, 7)) : 3'($urandom_range(0, 6));
    if (ld_busy) kind = (p < 85) ? t8cpu_pkg::KIND_LDRET : t8cpu_pkg::KIND_INSTR;
    else         kind = (p < 7)  ? t8cpu_pkg::KIND_LDRET : t8cpu_pkg::KIND_INSTR;
    send_item(kind, word, ldata);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (retired_q.size() != 0) @(posedge clk);
  endtask

  // result checking
  function automatic void check_field(string name, logic [DW-1:0] want, logic [DW-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      n_err++;
    end
  endfunction

  always @(posedge clk) begin : check_proc
    t8cpu_pkg::res_t want;
    t8cpu_pkg::res_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = t8cpu_pkg::res_t'(out_tdata[RES_W-1:0]);
      if (retired_q.size() == 0) begin
        $error("result transaction with nothing expected: %h", out_tdata);
        n_err++;
      end else begin
        want = retired_q.pop_front();
        check_field("fetch_pc",       want.fetch_pc,       got.fetch_pc);
        check_field("mem_request",    DW'(want.mem_request), DW'(got.mem_request));
        check_field("mem_address",    want.mem_address,    got.mem_address);
        check_field("mem_write_data", want.mem_write_data, got.mem_write_data);
        check_field("reg_written",    DW'(want.reg_written), DW'(got.reg_written));
        check_field("written_index",  DW'(want.written_index), DW'(got.written_index));
        check_field("written_value",  want.written_value,  got.written_value);
        check_field("halted_flag",    DW'(want.halted_flag), DW'(got.halted_flag));
        check_field("status",         DW'(want.status),    DW'(got.status));
        n_checked++;
        n_status[want.status]++;
      end
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin : rx_proc
    int n;
    int k;
    out_tready = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_len > 0) begin
        n        = hold_len;
        hold_len = 0;
        out_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end else begin
        n = rx_idle_en ? pick_gap() : 0;
        if (n > 0) begin
          out_tready <= 1'b0;
          repeat (n) @(posedge clk);
        end
      end
      out_tready <= 1'b1;
      n = $urandom_range(1, 12);
      @(posedge clk);
      for (k = 1; k < n && hold_len == 0; k++) @(posedge clk);
    end
  end

  task automatic test_directed();
    int sub;
    send_item(t8cpu_pkg::KIND_INSTR, iw(t8cpu_pkg::OP_ADDI, 3'd1, 3'd0, 3'd0, 8'hFF),
              8'h00); // r1 = ff
    send_item(t8cpu_pkg::KIND_INSTR, iw(t8cpu_pkg::OP_ADDI, 3'd2, 3'd0, 3'd0, 8'h7F),
              8'hFF); // r2 = 7f
    send_item(t8cpu_pkg::KIND_INSTR, iw(t8cpu_pkg::OP_ADDI, 3'd3, 3'd1, 3'd0, 8'h01),
              8'h00); // wraps to 0
    send_item(t8cpu_pkg::KIND_INSTR, iw(t8cpu_pkg::OP_ADD,  3'd4, 3'd1, 3'd2, 8'h00), 8'h00);
    send_item(t8cpu_pkg::KIND_INSTR, iw(t8cpu_pkg::OP_MUL,  3'd6, 3'd1, 3'd0, 8'h00),
              8'h00); // 15 * 15
    send_item(t8cpu_pkg::KIND_INSTR, iw(t8cpu_pkg::OP_INV,  3'd3, 3'd3, 3'd0, 8'h00), 8'h00);
    send_item(t8cpu_pkg::KIND_INSTR,
              iw(t8cpu_pkg::OP_BR, t8cpu_pkg::BR_EQ, 3'd1, 3'd3, 8'hFE), 8'h00); // taken
    send_item(t8cpu_pkg::KIND_INSTR, iw(t8cpu_pkg::OP_ADD,  3'd0, 3'd0, 3'd0, 8'h00), 8'h00);
    send_item(t8cpu_pkg::KIND_INSTR, iw(t8cpu_pkg::OP_ADDI, 3'd7, 3'd2, 3'd0, 8'h00),
              8'h00); // pc wraps
    send_item(t8cpu_pkg::KIND_INSTR,
              iw(t8cpu_pkg::OP_BR, t8cpu_pkg::BR_NE, 3'd1, 3'd3, 8'h55), 8'h00); // not taken
    send_item(t8cpu_pkg::KIND_INSTR,
              iw(t8cpu_pkg::OP_BR, t8cpu_pkg::BR_NE, 3'd1, 3'd2, 8'h40), 8'h00); // taken
    send_item(t8cpu_pkg::KIND_INSTR,
              iw(t8cpu_pkg::OP_BR, t8cpu_pkg::BR_LT, 3'd1, 3'd2, 8'h10), 8'h00); // -1 < 127
    send_item(t8cpu_pkg::KIND_INSTR,
              iw(t8cpu_pkg::OP_BR, t8cpu_pkg::BR_LT, 3'd2, 3'd1, 8'h20), 8'h00); // not taken
    // sub-codes above BR_LT only advance the PC
    for (sub = 3; sub < 8; sub++)
      send_item(t8cpu_pkg::KIND_INSTR, iw(t8cpu_pkg::OP_BR, sub[2:0], 3'd1, 3'd1, 8'hC3),
                8'h00);
    send_item(t8cpu_pkg::KIND_INSTR, iw(t8cpu_pkg::OP_STORE, 3'd0, 3'd2, 3'd1, 8'h00), 8'h00);
    send_item(t8cpu_pkg::KIND_INSTR, iw(t8cpu_pkg::OP_LOAD,  3'd5, 3'd0, 3'd2, 8'h00), 8'h00);
    send_item(t8cpu_pkg::KIND_INSTR, iw(t8cpu_pkg::OP_ADDI,  3'd0, 3'd0, 3'd0, 8'hFF),
              8'h00); // load pending
    send_item(t8cpu_pkg::KIND_LDRET, '1, 8'hA5);
    send_item(t8cpu_pkg::KIND_LDRET, '0, 8'h5A); // no load pending
    send_item(t8cpu_pkg::KIND_INSTR, iw(t8cpu_pkg::OP_ADD,   3'd7, 3'd7, 3'd7, 8'hFF), 8'hFF);
    send_item(t8cpu_pkg::KIND_INSTR, iw(t8cpu_pkg::OP_MUL,   3'd0, 3'd2, 3'd0, 8'h00), 8'h00);
  endtask

  task automatic test_random_mix(int count);
    repeat (count) send_random(1'b0);
  endtask

  task automatic test_back_to_back(int count);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    repeat (count) send_random(1'b0);
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  // receiver holds off while the sender keeps offering, so in_tready drops
  task automatic test_backpressure();
    tx_idle_en = 1'b0;
    hold_len   = 60;
    repeat (40) send_random(1'b0);
    tx_idle_en = 1'b1;
  endtask

  task automatic test_drain_pause();
    repeat (20) send_random(1'b0);
    wait_drained();
    repeat (20) send_random(1'b0);
  endtask

  // halt is sticky, everything after it is ignored
  task automatic test_halt();
    logic [IW_W-1:0] word;
    if (ld_busy) send_item(t8cpu_pkg::KIND_LDRET, IW_W'($urandom), DW'($urandom));
    word = IW_W'($urandom);
    word[19:17] = t8cpu_pkg::OP_HALT;
    send_item(t8cpu_pkg::KIND_INSTR, word, DW'($urandom));
    repeat (20) send_random(1'b1);
  endtask

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tuser   = t8cpu_pkg::KIND_INSTR;
    in_tdata   = '0;
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    foreach (gpr[i]) gpr[i] = '0;
    pc_q    = '0;
    halt_q  = 1'b0;
    ld_busy = 1'b0;
    ld_dst  = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random_mix(350);
    test_back_to_back(180);
    test_backpressure();
    test_drain_pause();
    test_halt();

    wait_drained();
    repeat (20) @(posedge clk);
    $display("%0d transactions sent, %0d results checked", n_sent, n_checked);
    $display("status ok/halted/busy/no-load: %0d/%0d/%0d/%0d",
             n_status[t8cpu_pkg::ST_OK], n_status[t8cpu_pkg::ST_HALTED],
             n_status[t8cpu_pkg::ST_BUSY], n_status[t8cpu_pkg::ST_NOLOAD]);
    if (n_err == 0) begin
      $display("** tiny_eight_bit_cpu_execute: PASSED **");
    end else begin
      $display("** tiny_eight_bit_cpu_execute: FAILED **");
    end
    $finish;
  end

endmodule

/* files.f */
src/t8cpu_pkg.sv
src/t8cpu_ram.sv
src/t8cpu_front.sv
src/t8cpu_queue.sv
src/t8cpu_back.sv
src/tiny_eight_bit_cpu_execute.sv
sim/tiny_eight_bit_cpu_execute_tb.sv
